FILE: sv/led_pkg.sv
package led_pkg;

  localparam int SampleW = 16;
  localparam int YW      = 48;
  localparam int EnergyW = 64;
  localparam int CountW  = 17;
  localparam int ThrW    = 32;
  localparam int MaxWindow = 65536;
  localparam int QDepth  = 2;

  localparam logic [CountW-1:0] MaxWindowC = CountW'(MaxWindow);

  // Q8.40 coefficients: b0..b2 then -a1..-a4
  localparam logic signed [63:0] FfCoef0 = 64'sd6179255;
  localparam logic signed [63:0] FfCoef1 = 64'sd24706026;
  localparam logic signed [63:0] FfCoef2 = 64'sd37053542;
  localparam logic signed [63:0] FbCoef0 = 64'sd4109314757650;
  localparam logic signed [63:0] FbCoef1 = -64'sd5768037999313;
  localparam logic signed [63:0] FbCoef2 = 64'sd3603539408873;
  localparam logic signed [63:0] FbCoef3 = -64'sd845414490597;

  localparam logic [1:0] AddrThreshold = 2'd0;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic                 detected;
    logic [EnergyW-1:0]   energy_sum;
    logic [CountW-1:0]    window_count;
  } result_t;

endpackage

FILE: sv/led_front.sv
module led_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_sample,
  input  logic                 in_last,
  output logic                 q_valid,
  input  logic                 q_ready,
  output led_pkg::item_t       q_item
);

  led_pkg::item_t mem_r [led_pkg::QDepth];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign in_ready = (cnt_r != 2'(led_pkg::QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].sample <= in_sample;
      mem_r[wp_r].last   <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: sv/led_back.sv
module led_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          threshold,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  led_pkg::item_t       q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output led_pkg::result_t     out_res
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAC  = 5'b00010,
    S_RND  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r;
  logic [3:0] step_r;
  logic [1:0] part_r;
  logic signed [15:0] xh_r [5];
  logic signed [47:0] yh_r [4];
  logic signed [127:0] acc_r;
  logic signed [47:0] y_r;
  logic [63:0] energy_r;
  logic [16:0] count_r;
  logic last_r;
  logic [63:0] limit_r;
  logic signed [63:0] ma, mb;
  logic [47:0] a_abs, b_abs;
  logic [31:0] op_a, op_b;
  logic [63:0] mul_out;
  logic [63:0] pp_r;
  logic [1:0] pp_sh_r;
  logic pp_ff_r, pp_neg_r, pp_v_r;
  logic [127:0] pp_w;
  logic signed [127:0] acc_nxt;

  // operand select: steps 0..4 feedforward, 5..8 feedback, 9 square
  always_comb begin
    ma = '0;
    mb = '0;
    case (step_r)
      4'd0: begin ma = led_pkg::FfCoef0; mb = 64'(xh_r[0]); end
      4'd1: begin ma = led_pkg::FfCoef1; mb = 64'(xh_r[1]); end
      4'd2: begin ma = led_pkg::FfCoef2; mb = 64'(xh_r[2]); end
      4'd3: begin ma = led_pkg::FfCoef1; mb = 64'(xh_r[3]); end
      4'd4: begin ma = led_pkg::FfCoef0; mb = 64'(xh_r[4]); end
      4'd5: begin ma = led_pkg::FbCoef0; mb = 64'(yh_r[0]); end
      4'd6: begin ma = led_pkg::FbCoef1; mb = 64'(yh_r[1]); end
      4'd7: begin ma = led_pkg::FbCoef2; mb = 64'(yh_r[2]); end
      4'd8: begin ma = led_pkg::FbCoef3; mb = 64'(yh_r[3]); end
      default: begin ma = 64'(y_r); mb = 64'(y_r); end
    endcase
  end

  // magnitudes fit in 48 bits; one 32x32 partial product a cycle
  always_comb begin
    a_abs = 48'(ma[63] ? -ma : ma);
    b_abs = 48'(mb[63] ? -mb : mb);
    case (part_r)
      2'd0: begin op_a = a_abs[31:0]; op_b = b_abs[31:0]; end
      2'd1: begin op_a = a_abs[31:0]; op_b = {16'd0, b_abs[47:32]}; end
      2'd2: begin op_a = {16'd0, a_abs[47:32]}; op_b = b_abs[31:0]; end
      default: begin op_a = {16'd0, a_abs[47:32]}; op_b = {16'd0, b_abs[47:32]}; end
    endcase
    mul_out = 64'(op_a) * 64'(op_b);
  end

  always_ff @(posedge clk) begin
    pp_r     <= mul_out;
    pp_sh_r  <= (part_r == 2'd0) ? 2'd0 : ((part_r == 2'd3) ? 2'd2 : 2'd1);
    pp_ff_r  <= (step_r <= 4'd4);
    pp_neg_r <= ma[63] ^ mb[63];
  end

  // align the partial product (feedforward terms up 24 more bits), apply the sign and add it in
  always_comb begin
    case (pp_sh_r)
      2'd0: pp_w = 128'(pp_r);
      2'd1: pp_w = {32'd0, pp_r, 32'd0};
      default: pp_w = {pp_r, 64'd0};
    endcase
    if (pp_ff_r) pp_w = pp_w << 24;
    acc_nxt = acc_r + (pp_w ^ {128{pp_neg_r}}) + 128'(pp_neg_r);
  end

  logic signed [127:0] rnd;
  logic signed [87:0]  shf;
  logic signed [47:0]  ysat;
  logic [63:0] term, esum;
  logic [64:0] esum_w;
  logic [15:0] half;

  always_comb begin
    rnd = acc_r + (128'sd1 <<< 39);
    shf = rnd[127:40];
    if (shf > 88'sh7FFFFFFFFFFF) ysat = 48'sh7FFFFFFFFFFF;
    else if (shf < -88'sh800000000000) ysat = 48'sh800000000000;
    else ysat = shf[47:0];
    term = acc_r[103:40];
    esum_w = {1'b0, energy_r} + {1'b0, term};
    esum = esum_w[64] ? '1 : esum_w[63:0];
    half = count_r[16:1];
  end

  assign q_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
      part_r <= '0;
      pp_v_r <= 1'b0;
      energy_r <= '0;
      count_r <= '0;
      for (int k = 0; k < 5; k++) xh_r[k] <= '0;
      for (int k = 0; k < 4; k++) yh_r[k] <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          pp_v_r <= 1'b0;
          if (q_valid) begin
            for (int k = 4; k > 0; k--) xh_r[k] <= xh_r[k-1];
            xh_r[0] <= q_item.sample;
            last_r <= q_item.last;
            acc_r <= '0;
            step_r <= 4'd0;
            part_r <= 2'd0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          // issue one partial product a cycle; accumulate the previous one
          pp_v_r <= 1'b1;
          if (pp_v_r) acc_r <= acc_nxt;
          part_r <= part_r + 2'd1;
          if (part_r == 2'd3) begin
            if (step_r == 4'd8) state_r <= S_RND;
            else if (step_r == 4'd9) state_r <= S_FIN;
            else step_r <= step_r + 4'd1;
          end
        end
        S_RND: begin
          pp_v_r <= 1'b0;
          if (pp_v_r) begin
            acc_r <= acc_nxt;
          end else begin
            // filter sum complete: round and saturate, then square it
            y_r <= ysat;
            acc_r <= '0;
            step_r <= 4'd9;
            state_r <= S_MAC;
          end
        end
        S_FIN: begin
          pp_v_r <= 1'b0;
          if (pp_v_r) begin
            acc_r <= acc_nxt;
          end else begin
            energy_r <= esum;
            count_r <= count_r + 17'd1;
            for (int k = 3; k > 0; k--) yh_r[k] <= yh_r[k-1];
            yh_r[0] <= y_r;
            limit_r <= 64'(threshold) * 64'(count_r[16:0] + 17'd1 >> 1);
            if (last_r || (count_r + 17'd1) >= led_pkg::MaxWindowC)
              state_r <= S_OUT;
            else
              state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            energy_r <= '0;
            count_r <= '0;
            for (int k = 0; k < 5; k++) xh_r[k] <= '0;
            for (int k = 0; k < 4; k++) yh_r[k] <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_res.detected = (half == 16'd0) ? (energy_r != 64'd0) : (energy_r >= limit_r);
  assign out_res.energy_sum = energy_r;
  assign out_res.window_count = count_r;

endmodule

FILE: sv/lowpass_energy_detector.sv
// Lowpass energy detector. Samples enter through a two-entry queue; the back
// end accepts one only while idle and works on it with the single shared
// 32x32 multiplier: the nine filter products and the square are each built
// from four partial products, one a cycle, and the filter sum is closed and
// rounded before the square, which is then added to the energy. A window ends
// with its last sample or at 65536 samples; its result is held at the output
// until taken, after which filter history, energy and count clear.
module lowpass_energy_detector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_sample,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_detected,
  output logic [63:0]        out_energy_sum,
  output logic [16:0]        out_window_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] thr_r;
  logic q_valid, q_ready;
  led_pkg::item_t q_item;
  led_pkg::result_t res;

  assign pready = 1'b1;
  assign prdata = (paddr == led_pkg::AddrThreshold) ? thr_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 32'd256;
    else if (psel && penable && pwrite && paddr == led_pkg::AddrThreshold) thr_r <= pwdata;
  end

  led_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_sample, .in_last,
    .q_valid, .q_ready, .q_item
  );

  led_back u_back (
    .clk, .rst_n, .threshold(thr_r), .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_detected = res.detected;
  assign out_energy_sum = res.energy_sum;
  assign out_window_count = res.window_count;

endmodule
